>>> src/glf_pkg.sv
// ----------------------------------------------------------------------------
// glf_pkg: shared types and constants for the G-code line framer
// Character codes, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package glf_pkg;

    localparam int HOLD_DEPTH  = 32;
    localparam int NUMBER_BITS = 32;
    localparam int HOLD_IDX_W  = $clog2(HOLD_DEPTH);
    localparam int HOLD_CNT_W  = $clog2(HOLD_DEPTH + 1);
    localparam int DIGITS_MAX  = 10;
    localparam int DIG_IDX_W   = 4;

    // floor(v * DIV10_RECIP / 2^35) == v / 10 for every 32-bit v
    localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,     // split number into digits, one per cycle
        ST_EMIT_N,
        ST_EMIT_DIG,
        ST_EMIT_SP,
        ST_FLUSH,
        ST_EMIT_BYTE,
        ST_TAIL,     // store held whitespace, decide end-of-line handling
        ST_EMIT_STAR,
        ST_EMIT_NL
    } state_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

>>> src/gcode_line_framer_unit.sv
// ----------------------------------------------------------------------------
// gcode_line_framer_unit: frames raw G-code lines with number and checksum
// Emits "N<num> <line>*<xor>\n" one byte per output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per raw byte
//   (func=0) or a counter load (func=1). Output channel (out_valid/
//   out_stall) delivers one framed byte per transaction; frame_end marks
//   the closing newline, frame_number the line number in use.
//   An item is taken in IDLE, then the sequencer runs until every byte it
//   causes has been delivered; its emitting states give one byte per cycle
//   when the receiver does not stall. The first printable byte of a line
//   first runs each digit of the line number through the shared
//   divide-by-ten unit, then emits the digits (up to 10 digits). A flush
//   emits each held whitespace byte (up to 32); a line end emits up to 5
//   bytes: '*', up to 3 checksum digits and the newline.
//   The block accepts no item while a previous one is in work.
//   Reset clears counter, checksum and line flags; the hold memory is not
//   cleared, only entries below the held count are ever read.
//   A stall holds the output byte in its register and pauses the emitting states.
// ----------------------------------------------------------------------------
module gcode_line_framer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        line_end,
    input  logic [31:0] counter_load,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic [31:0] frame_number
);
    import glf_pkg::*;

    state_t state_reg, state_next;

    logic [NUMBER_BITS-1:0] lines_reg, lines_next;
    logic [7:0]             xor_reg, xor_next;
    logic                   prefix_reg, prefix_next;
    logic                   comment_reg, comment_next;
    logic [HOLD_CNT_W-1:0]  held_reg, held_next;
    logic [HOLD_CNT_W-1:0]  fidx_reg, fidx_next;

    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic                   append_reg, append_next; // store byte in hold; checksum path when emitting

    logic [NUMBER_BITS-1:0] num_reg, num_next;
    logic [3:0]             dig_reg [DIGITS_MAX];
    logic [DIG_IDX_W-1:0]   ndig_reg, ndig_next;
    logic                   dig_we;

    logic                   ov_reg, ov_next;
    logic [7:0]             ob_reg, ob_next;
    logic                   oe_reg, oe_next;

    logic [7:0]             hold_mem [HOLD_DEPTH];
    logic [7:0]             hold_rd;
    logic                   hold_we;

    logic [NUMBER_BITS-1:0] q;
    logic [3:0]             r;
    logic                   emit_ok;

    glf_div10 u_div (.value(num_reg), .quotient(q), .remainder(r));

    assign in_stall     = (state_reg != ST_IDLE) || ov_reg;
    assign out_valid    = ov_reg;
    assign out_byte     = ob_reg;
    assign frame_end    = oe_reg;
    assign frame_number = 32'(lines_reg);
    assign emit_ok      = !ov_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (hold_we)
            hold_mem[held_reg[HOLD_IDX_W-1:0]] <= byte_reg;
        hold_rd <= hold_mem[fidx_next[HOLD_IDX_W-1:0]];
        if (dig_we)
            dig_reg[ndig_reg] <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lines_reg   <= '0;
            xor_reg     <= '0;
            prefix_reg  <= 1'b0;
            comment_reg <= 1'b0;
            held_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lines_reg   <= lines_next;
            xor_reg     <= xor_next;
            prefix_reg  <= prefix_next;
            comment_reg <= comment_next;
            held_reg    <= held_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fidx_reg   <= fidx_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        append_reg <= append_next;
        num_reg    <= num_next;
        ndig_reg   <= ndig_next;
        ob_reg     <= ob_next;
        oe_reg     <= oe_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        lines_next   = lines_reg;
        xor_next     = xor_reg;
        prefix_next  = prefix_reg;
        comment_next = comment_reg;
        held_next    = held_reg;
        fidx_next    = fidx_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        append_next  = append_reg;
        num_next     = num_reg;
        ndig_next    = ndig_reg;
        ov_next      = ov_reg && out_stall;
        ob_next      = ob_reg;
        oe_next      = oe_reg;
        hold_we      = 1'b0;
        dig_we       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (func)
                        lines_next = counter_load[NUMBER_BITS-1:0];
                    else
                    begin
                        byte_next   = data_byte;
                        last_next   = line_end;
                        append_next = 1'b0;
                        fidx_next   = '0;
                        state_next  = ST_TAIL;
                        if (!comment_reg)
                        begin
                            if (data_byte == CH_SEMI)
                                comment_next = 1'b1;
                            else if (is_space(data_byte))
                            begin
                                if (prefix_reg)
                                begin
                                    if (held_reg == HOLD_CNT_W'(HOLD_DEPTH))
                                    begin
                                        append_next = 1'b1;
                                        state_next  = ST_FLUSH;
                                    end
                                    else
                                    begin
                                        // stored next cycle from byte_reg
                                        append_next = 1'b1;
                                        state_next  = ST_TAIL;
                                    end
                                end
                            end
                            else if (!prefix_reg)
                            begin
                                lines_next  = lines_reg + NUMBER_BITS'(1);
                                num_next    = lines_reg + NUMBER_BITS'(1);
                                ndig_next   = '0;
                                xor_next    = '0;
                                prefix_next = 1'b1;
                                state_next  = ST_CONV;
                            end
                            else
                                state_next = ST_FLUSH;
                        end
                    end
                end
            end

            ST_CONV:
            begin
                dig_we    = 1'b1;
                num_next  = q;
                ndig_next = ndig_reg + DIG_IDX_W'(1);
                if (q == '0 || ndig_reg == DIG_IDX_W'(DIGITS_MAX - 1))
                    state_next = ST_EMIT_N;
            end

            ST_EMIT_N:
            begin
                // reached for prefix (xor accumulates) or checksum (not)
                if (emit_ok)
                begin
                    ov_next = 1'b1;
                    oe_next = 1'b0;
                    if (append_reg)
                    begin
                        // checksum path: digits already converted
                        ob_next    = CH_ZERO | {4'd0, dig_reg[ndig_reg - DIG_IDX_W'(1)]};
                        ndig_next  = ndig_reg - DIG_IDX_W'(1);
                        state_next = (ndig_reg == DIG_IDX_W'(1)) ? ST_EMIT_NL : ST_EMIT_DIG;
                    end
                    else
                    begin
                        ob_next    = CH_N;
                        xor_next   = xor_reg ^ CH_N;
                        state_next = ST_EMIT_DIG;
                    end
                end
            end

            ST_EMIT_DIG:
            begin
                if (emit_ok)
                begin
                    ov_next   = 1'b1;
                    oe_next   = 1'b0;
                    ob_next   = CH_ZERO | {4'd0, dig_reg[ndig_reg - DIG_IDX_W'(1)]};
                    ndig_next = ndig_reg - DIG_IDX_W'(1);
                    if (!append_reg)
                        xor_next = xor_reg ^ (CH_ZERO | {4'd0, dig_reg[ndig_reg - DIG_IDX_W'(1)]});
                    if (ndig_reg == DIG_IDX_W'(1))
                        state_next = append_reg ? ST_EMIT_NL : ST_EMIT_SP;
                end
            end

            ST_EMIT_SP:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    oe_next    = 1'b0;
                    ob_next    = CH_SPACE;
                    xor_next   = xor_reg ^ CH_SPACE;
                    state_next = ST_EMIT_BYTE;
                end
            end

            ST_FLUSH:
            begin
                if (fidx_reg == held_reg)
                begin
                    held_next  = '0;
                    fidx_next  = '0;
                    state_next = append_reg ? ST_TAIL : ST_EMIT_BYTE;
                end
                else if (emit_ok)
                begin
                    ov_next   = 1'b1;
                    oe_next   = 1'b0;
                    ob_next   = hold_rd;
                    xor_next  = xor_reg ^ hold_rd;
                    fidx_next = fidx_reg + HOLD_CNT_W'(1);
                end
            end

            ST_EMIT_BYTE:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    oe_next    = 1'b0;
                    ob_next    = byte_reg;
                    xor_next   = xor_reg ^ byte_reg;
                    state_next = ST_TAIL;
                end
            end

            ST_TAIL:
            begin
                if (append_reg && !last_reg)
                begin
                    hold_we     = 1'b1;
                    held_next   = held_reg + HOLD_CNT_W'(1);
                end
                append_next = 1'b0;
                if (!last_reg)
                    state_next = ST_IDLE;
                else
                begin
                    held_next    = '0;
                    comment_next = 1'b0;
                    if (prefix_reg)
                        state_next = ST_EMIT_STAR;
                    else
                    begin
                        xor_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT_STAR:
            begin
                if (emit_ok)
                begin
                    ov_next     = 1'b1;
                    oe_next     = 1'b0;
                    ob_next     = CH_STAR;
                    num_next    = NUMBER_BITS'(xor_reg);
                    ndig_next   = '0;
                    append_next = 1'b1;
                    state_next  = ST_CONV;
                end
            end

            ST_EMIT_NL:
            begin
                if (emit_ok)
                begin
                    ov_next     = 1'b1;
                    oe_next     = 1'b1;
                    ob_next     = CH_NL;
                    xor_next    = '0;
                    prefix_next = 1'b0;
                    append_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        if (state_reg == ST_FLUSH && fidx_reg == held_reg && append_reg)
            append_next = 1'b1;
    end
endmodule

>>> src/glf_div10.sv
// ----------------------------------------------------------------------------
// glf_div10: divide by ten with remainder
// Reciprocal multiply, exact for 32-bit values; one digit per use.
// ----------------------------------------------------------------------------
module glf_div10 (
    input  logic [glf_pkg::NUMBER_BITS-1:0] value,
    output logic [glf_pkg::NUMBER_BITS-1:0] quotient,
    output logic [3:0]                      remainder
);
    import glf_pkg::*;

    logic [63:0]            prod;
    logic [NUMBER_BITS-1:0] back;

    // 32x32 multiply by the reciprocal, then take the remainder back out
    always_comb
    begin
        prod      = {32'd0, 32'(value)} * {32'd0, DIV10_RECIP};
        quotient  = NUMBER_BITS'(prod >> 35);
        back      = quotient * NUMBER_BITS'(10);
        remainder = 4'(value - back);
    end
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the G-code line framer
// A directed table of raw bytes and counter loads runs first, then a hold
// overflow line, a receiver hold-off and random lines. Every framed byte is
// checked against an internal model of the framer, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import glf_pkg::*;

    localparam logic FN_BYTE = 1'b0;
    localparam logic FN_LOAD = 1'b1;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef struct packed {
        logic        func;
        logic [7:0]  data;
        logic        last;
        logic [31:0] load;
    } line_item_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic [31:0] num;
    } frame_byte_t;

    // One row of the directed table. has_exp marks rows whose first
    // framed byte is typed in by hand.
    typedef struct packed {
        line_item_t  item;
        logic        has_exp;
        frame_byte_t first_exp;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [7:0]  data_byte;
    logic        line_end;
    logic [31:0] counter_load;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic [31:0] frame_number;

    gcode_line_framer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .data_byte    (data_byte),
        .line_end     (line_end),
        .counter_load (counter_load),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .frame_end    (frame_end),
        .frame_number (frame_number)
    );

    // ------------------------------------------------------------------
    // Framer model state
    // ------------------------------------------------------------------
    logic [31:0] mdl_lines;
    logic [7:0]  mdl_xor;
    logic        mdl_prefix;
    logic        mdl_comment;
    logic [7:0]  mdl_hold [HOLD_DEPTH];
    int          mdl_held;

    frame_byte_t expected_bytes [$];
    int          fail_count;
    int          pred_base;      // queue size before the last prediction
    bit          hold_off_req;   // asks the receiver for a long stall
    bit          hold_off_done;

    function automatic bit ws(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // Queue one framed byte, optionally folding it into the checksum.
    function automatic void push_byte(input logic [7:0] b, input logic fin,
                                      input bit add_xor);
        frame_byte_t f;
        f.ch  = b;
        f.fin = fin;
        f.num = mdl_lines;
        expected_bytes.insert(expected_bytes.size(), f);
        if (add_xor)
            mdl_xor ^= b;
    endfunction

    function automatic void push_decimal(input logic [31:0] v, input bit add_xor);
        logic [7:0] dig [10];
        int n;
        n = 0;
        do begin
            dig[n] = CH_ZERO + 8'(v % 10);
            v = v / 10;
            n++;
        end while (v != 0);
        while (n > 0) begin
            n--;
            push_byte(dig[n], 1'b0, add_xor);
        end
    endfunction

    function automatic void flush_spaces();
        for (int i = 0; i < mdl_held; i++)
            push_byte(mdl_hold[i], 1'b0, 1'b1);
        mdl_held = 0;
    endfunction

    // Works out the framed bytes caused by one accepted transaction.
    function automatic void frame_predict(input line_item_t it);
        logic [7:0] cs;
        if (it.func == FN_LOAD) begin
            mdl_lines = it.load;
            return;
        end
        if (!mdl_comment) begin
            if (it.data == CH_SEMI) begin
                mdl_comment = 1'b1;
            end
            else if (ws(it.data)) begin
                if (mdl_prefix) begin
                    if (mdl_held >= HOLD_DEPTH)
                        flush_spaces();
                    mdl_hold[mdl_held] = it.data;
                    mdl_held++;
                end
            end
            else begin
                if (!mdl_prefix) begin
                    mdl_lines  = mdl_lines + 32'd1;
                    mdl_xor    = '0;
                    mdl_prefix = 1'b1;
                    push_byte(CH_N, 1'b0, 1'b1);
                    push_decimal(mdl_lines, 1'b1);
                    push_byte(CH_SPACE, 1'b0, 1'b1);
                end
                else begin
                    flush_spaces();
                end
                push_byte(it.data, 1'b0, 1'b1);
            end
        end
        if (it.last) begin
            mdl_held = 0;
            if (mdl_prefix) begin
                cs = mdl_xor;
                push_byte(CH_STAR, 1'b0, 1'b0);
                push_decimal({24'd0, cs}, 1'b0);
                push_byte(CH_NL, 1'b1, 1'b0);
            end
            mdl_xor     = '0;
            mdl_prefix  = 1'b0;
            mdl_comment = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and timeout
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        // Worst case is far below this: ~500 items of up to 38 bytes,
        // random gaps and stalls, plus the long hold-off.
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    line_item_t stim_queue [$];
    table_row_t directed [$];

    function automatic line_item_t mk(input logic f, input logic [7:0] d,
                                      input logic l, input logic [31:0] ld);
        line_item_t it;
        it.func = f;
        it.data = d;
        it.last = l;
        it.load = ld;
        return it;
    endfunction

    function automatic table_row_t row(input line_item_t it, input bit he,
                                       input logic [7:0] ch, input logic [31:0] num);
        table_row_t r;
        r.item      = it;
        r.has_exp   = he;
        r.first_exp = '{ch: ch, fin: 1'b0, num: num};
        return r;
    endfunction

    function automatic void add_row(input table_row_t r);
        directed.insert(directed.size(), r);
    endfunction

    function automatic void add_stim(input line_item_t it);
        stim_queue.insert(stim_queue.size(), it);
    endfunction

    // Random byte that is neither whitespace nor ';'.
    function automatic logic [7:0] rand_print();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (ws(b) || b == CH_SEMI);
        return b;
    endfunction

    function automatic logic [7:0] rand_space();
        return ($urandom_range(0, 3) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    // Queues a random, mostly well-formed line.
    task automatic add_random_line();
        int len;
        int kind;
        logic [7:0] b;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 19);
            if (kind < 11)
                b = rand_print();
            else if (kind < 18)
                b = rand_space();
            else if (kind == 18)
                b = CH_SEMI;
            else
                b = 8'($urandom_range(0, 255));
            add_stim(mk(FN_BYTE, b, i == len - 1, $urandom));
        end
    endtask

    int accepted_items;

    // Valid drops only when a gap is drawn, so back-to-back items keep it high.
    task automatic send_item(input line_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= it.func;
        data_byte    <= it.data;
        line_end     <= it.last;
        counter_load <= it.load;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pred_base = expected_bytes.size();
        frame_predict(it);
        accepted_items++;
    endtask

    task automatic send_queued();
        line_item_t nxt;
        while (stim_queue.size() != 0) begin
            nxt = stim_queue[0];
            stim_queue.delete(0);
            send_item(nxt);
        end
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_bytes.size() != 0) @(posedge clk);
    endtask

    initial begin
        logic [31:0] ld;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FN_BYTE;
        data_byte    = '0;
        line_end     = 1'b0;
        counter_load = '0;
        fail_count   = 0;
        pred_base    = 0;
        accepted_items = 0;
        hold_off_req = 1'b0;
        hold_off_done = 1'b0;
        mdl_lines = '0; mdl_xor = '0; mdl_prefix = 1'b0; mdl_comment = 1'b0;
        mdl_held = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: first line after reset is N1, extremes of the
        // counter, comments, empty lines, tabs and CR, all-ones bytes.
        add_row(row(mk(FN_BYTE, CH_SPACE, 1'b0, 32'd0), 1'b0, 8'h00, 32'd0)); // leading ws
        add_row(row(mk(FN_BYTE, 8'h47, 1'b0, 32'd0), 1'b1, CH_N, 32'd1));
        add_row(row(mk(FN_BYTE, CH_TAB, 1'b0, 32'd0), 1'b0, 8'h00, 32'd0));
        add_row(row(mk(FN_BYTE, 8'h31, 1'b0, 32'd0), 1'b0, 8'h00, 32'd0));
        add_row(row(mk(FN_BYTE, CH_CR, 1'b1, 32'd0), 1'b0, 8'h00, 32'd0));   // trailing ws
        add_row(row(mk(FN_BYTE, CH_SEMI, 1'b1, 32'd0), 1'b0, 8'h00, 32'd0)); // empty line
        add_row(row(mk(FN_BYTE, 8'h0B, 1'b1, 32'd0), 1'b0, 8'h00, 32'd0));   // ws only
        add_row(row(mk(FN_LOAD, 8'hFF, 1'b1, 32'hFFFF_FFFE), 1'b0, 8'h00, 32'd0));
        add_row(row(mk(FN_BYTE, 8'hFF, 1'b1, 32'd0), 1'b1, CH_N, 32'hFFFF_FFFF));
        add_row(row(mk(FN_BYTE, 8'h00, 1'b0, 32'd0), 1'b1, CH_N, 32'd0)); // wrap
        add_row(row(mk(FN_BYTE, CH_SEMI, 1'b0, 32'd0), 1'b0, 8'h00, 32'd0)); // comment
        add_row(row(mk(FN_BYTE, 8'h41, 1'b0, 32'd0), 1'b0, 8'h00, 32'd0));
        add_row(row(mk(FN_LOAD, 8'h00, 1'b0, 32'd99), 1'b0, 8'h00, 32'd0)); // mid-frame
        add_row(row(mk(FN_BYTE, 8'h7F, 1'b1, 32'd0), 1'b0, 8'h00, 32'd0));
        add_row(row(mk(FN_BYTE, 8'h80, 1'b0, 32'd0), 1'b1, CH_N, 32'd100));
        add_row(row(mk(FN_BYTE, 8'h0C, 1'b0, 32'd0), 1'b0, 8'h00, 32'd0));
        add_row(row(mk(FN_BYTE, 8'h0A, 1'b0, 32'd0), 1'b0, 8'h00, 32'd0));
        add_row(row(mk(FN_BYTE, 8'h01, 1'b1, 32'd0), 1'b0, 8'h00, 32'd0));
        add_row(row(mk(FN_LOAD, 8'h00, 1'b0, 32'd0), 1'b0, 8'h00, 32'd0));

        foreach (directed[i]) begin
            send_item(directed[i].item);
            if (directed[i].has_exp && expected_bytes.size() > pred_base
                && expected_bytes[pred_base] !== directed[i].first_exp) begin
                $display("%0t: table row %0d expected %p, model %p", $time, i,
                         directed[i].first_exp, expected_bytes[pred_base]);
                fail_count++;
            end
        end

        // Hold store overflow: more than HOLD_DEPTH spaces in one line.
        send_item(mk(FN_BYTE, 8'h58, 1'b0, 32'd0));
        for (int i = 0; i < HOLD_DEPTH + 5; i++)
            send_item(mk(FN_BYTE, rand_space(), 1'b0, 32'd0));
        send_item(mk(FN_BYTE, 8'h59, 1'b1, 32'd0));

        // Receiver holds off while lines keep coming in, so the block
        // backs up and stalls its input.
        hold_off_req = 1'b1;
        for (int i = 0; i < 4; i++)
            add_random_line();
        send_queued();
        release_input();
        wait (hold_off_done);

        // Sender pauses until everything has come out.
        wait_drained();

        while (accepted_items < 480) begin
            if ($urandom_range(0, 15) == 0) begin
                ld = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF - 3;
                add_stim(mk(FN_LOAD, 8'($urandom), 1'($urandom_range(0, 1)), ld));
            end
            add_random_line();
            send_queued();
        end
        release_input();

        fork
            wait_drained();
            begin
                repeat (200000) @(posedge clk);
            end
        join_any
        repeat (64) @(posedge clk);
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        int wait_cyc;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off_done = 1'b1;
            end
            wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (wait_cyc != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cyc) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Output check: every accepted transaction against the oldest expected byte.
    always @(posedge clk) begin
        frame_byte_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %h fin %b num %0d", $time,
                         out_byte, frame_end, frame_number);
                fail_count++;
            end
            else begin
                e = expected_bytes[0];
                expected_bytes.delete(0);
                if (out_byte !== e.ch) begin
                    $display("%0t: out_byte expected %h got %h", $time, e.ch, out_byte);
                    fail_count++;
                end
                if (frame_end !== e.fin) begin
                    $display("%0t: frame_end expected %b got %b", $time, e.fin, frame_end);
                    fail_count++;
                end
                if (frame_number !== e.num) begin
                    $display("%0t: frame_number expected %0d got %0d", $time,
                             e.num, frame_number);
                    fail_count++;
                end
            end
        end
    end

endmodule

>>> filelist.f
src/glf_pkg.sv
src/glf_div10.sv
src/gcode_line_framer_unit.sv
tb/sv/tb_top.sv
